FILE: design/token_threaded_stack_machine_macros.svh
// Assertion helpers for the stack machine core.
`ifndef TOKEN_THREADED_STACK_MACHINE_MACROS_SVH
`define TOKEN_THREADED_STACK_MACHINE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during rst.
`define TTS_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("stack machine check failed");
// Next-cycle implication, sampled on clk, off during rst.
`define TTS_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("stack machine check failed");
`else
`define TTS_ASSERT_IMP(label, cond, prop)
`define TTS_ASSERT_NXT(label, cond, prop)
`endif
`endif

FILE: design/tts_pkg.sv
package tts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_BITS   = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CELL_W      = 64;
  localparam int OP_W        = 8;
  localparam int KEY_W       = 9;
  localparam int OUT_ADDR_W  = 16;
  localparam int KIND_W      = 3;

  typedef logic [SP_W-1:0]             sp_t;
  typedef logic [ADDR_BITS-1:0]        addr_t;
  typedef logic signed [CELL_W-1:0]    cell_t;

  localparam sp_t SP_MAX = sp_t'(STACK_DEPTH - 1);

  typedef enum logic [OP_W-1:0] {
    OP_BYE   = 8'd0,
    OP_KEY   = 8'd1,
    OP_EMIT  = 8'd2,
    OP_CALL  = 8'd3,
    OP_EXIT  = 8'd4,
    OP_LIT   = 8'd5,
    OP_DUP   = 8'd6,
    OP_DROP  = 8'd7,
    OP_DEC   = 8'd8,
    OP_INC   = 8'd9,
    OP_ADD   = 8'd10,
    OP_MUL2  = 8'd11,
    OP_DIV2  = 8'd12,
    OP_SWAP  = 8'd13,
    OP_JZ    = 8'd14,
    OP_JUMP  = 8'd15,
    OP_ZEQ   = 8'd16,
    OP_ROT   = 8'd17,
    OP_AND   = 8'd18,
    OP_MAX   = 8'd19,
    OP_GT    = 8'd20,
    OP_PRINT = 8'd21
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 3'd0,
    KIND_EMIT    = 3'd1,
    KIND_PRINT   = 3'd2,
    KIND_BYE     = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_t;

  typedef struct packed {
    logic  en;
    sp_t   addr;
    cell_t data;
  } ds_wr_t;

  typedef struct packed {
    logic  en;
    sp_t   addr;
    addr_t data;
  } rs_wr_t;

  // Decoded item handed from issue to execute.
  typedef struct packed {
    logic              skip;
    logic [OP_W-1:0]   op;
    cell_t             imm;
    logic [KEY_W-1:0]  key;
    logic              fault;
    sp_t               ra0;
    sp_t               ra1;
    sp_t               wpush;
    sp_t               rwa;
    logic              fwd0;
    logic              fwd1;
    logic              rfwd;
    cell_t             fwd0_data;
    cell_t             fwd1_data;
    addr_t             rfwd_data;
  } iss_t;

  typedef struct packed {
    logic busy;
    logic adv;
    logic rot;
  } ex_stat_t;

endpackage

FILE: design/tts_cmd_if.sv
interface tts_cmd_if;
  import tts_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [CELL_W-1:0] inline_cell;
  logic signed [KEY_W-1:0] key_char;
  modport source (output valid, opcode, inline_cell, key_char, input ready);
  modport sink   (input valid, opcode, inline_cell, key_char, output ready);
endinterface

FILE: design/tts_res_if.sv
interface tts_res_if;
  import tts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OUT_ADDR_W-1:0]    next_address;
  logic [KIND_W-1:0]        out_kind;
  logic signed [CELL_W-1:0] out_value;
  logic                     stack_fault;
  modport source (output valid, next_address, out_kind, out_value, stack_fault,
                  input ready);
  modport sink   (input valid, next_address, out_kind, out_value, stack_fault,
                  output ready);
endinterface

FILE: design/tts_cfg_if.sv
interface tts_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_address;
  modport source (output valid, start_address, input ready);
  modport sink   (input valid, start_address, output ready);
endinterface

FILE: design/token_threaded_stack_machine.sv
// An item is registered at issue, then execute loads the output register.
// Throughput: one item per cycle; an output stall holds execute and the input, and
// a rot blocks the input until its second data stack write goes out.
// Reset (rst, synchronous): pointers, top of stack, address and halt clear;
// stack memories keep their contents and need no clearing pass.
`include "token_threaded_stack_machine_macros.svh"

module token_threaded_stack_machine import tts_pkg::*; (
  input logic     clk,
  input logic     rst,
  tts_cfg_if.sink cfg,
  tts_cmd_if.sink cmd,
  tts_res_if.source res
);

  // Two stages:
  //  issue   - decode the opcode, move both stack pointers, start the memory
  //            reads at the current pointers, catch writes to those entries.
  //  execute - apply the opcode to the cached top of stack, write the stacks,
  //            load the output register.
  // The data stack is kept as two copies written alike, giving two read ports.

  logic     cmd_accept, cfg_wr;
  ex_stat_t stat;
  ds_wr_t   ds_wr;
  rs_wr_t   rs_wr;
  iss_t     iss;
  sp_t      ds_raddr0, ds_raddr1, rs_raddr;
  cell_t    ds_rdata0, ds_rdata1;
  addr_t    rs_rdata;

  // Configuration is always taken; the user must send it only while the core is idle, the core does not enforce this.
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  // Take a new item when execute is empty or drains this cycle, but not
  // behind a rot, whose late write must land before the next read.
  assign cmd.ready  = !stat.busy || (stat.adv && !stat.rot);
  assign cmd_accept = cmd.valid && cmd.ready;

  tts_issue u_issue (
    .clk         (clk),
    .rst         (rst),
    .accept      (cmd_accept),
    .opcode      (cmd.opcode),
    .inline_cell (cmd.inline_cell),
    .key_char    (cmd.key_char),
    .cfg_wr      (cfg_wr),
    .ds_wr       (ds_wr),
    .rs_wr       (rs_wr),
    .ds_raddr0   (ds_raddr0),
    .ds_raddr1   (ds_raddr1),
    .rs_raddr    (rs_raddr),
    .iss         (iss)
  );

  tts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(CELL_W)) u_ds_ram0 (
    .clk   (clk),
    .we    (ds_wr.en),
    .waddr (ds_wr.addr),
    .wdata (ds_wr.data),
    .re    (cmd_accept),
    .raddr (ds_raddr0),
    .rdata (ds_rdata0)
  );

  tts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(CELL_W)) u_ds_ram1 (
    .clk   (clk),
    .we    (ds_wr.en),
    .waddr (ds_wr.addr),
    .wdata (ds_wr.data),
    .re    (cmd_accept),
    .raddr (ds_raddr1),
    .rdata (ds_rdata1)
  );

  tts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(ADDR_BITS)) u_rs_ram (
    .clk   (clk),
    .we    (rs_wr.en),
    .waddr (rs_wr.addr),
    .wdata (rs_wr.data),
    .re    (cmd_accept),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  tts_exec u_exec (
    .clk              (clk),
    .rst              (rst),
    .accept           (cmd_accept),
    .iss              (iss),
    .ds_rdata0        (ds_rdata0),
    .ds_rdata1        (ds_rdata1),
    .rs_rdata         (rs_rdata),
    .cfg_wr           (cfg_wr),
    .cfg_start        (cfg.start_address),
    .res_ready        (res.ready),
    .stat             (stat),
    .ds_wr            (ds_wr),
    .rs_wr            (rs_wr),
    .res_valid        (res.valid),
    .res_next_address (res.next_address),
    .res_out_kind     (res.out_kind),
    .res_out_value    (res.out_value),
    .res_stack_fault  (res.stack_fault)
  );

  // A transfer in always fills execute.
  `TTS_ASSERT_NXT(a_issue_fills_exec, cmd_accept, stat.busy)
  // A rot that executes writes its second entry on the next cycle.
  `TTS_ASSERT_NXT(a_rot_late_write, stat.adv && stat.rot && !iss.skip, ds_wr.en)
  // With the output held and execute full, no new item comes in.
  `TTS_ASSERT_IMP(a_hold_on_stall, res.valid && !res.ready && stat.busy, !cmd_accept)

endmodule

FILE: design/tts_ram.sv
module tts_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/tts_issue.sv
module tts_issue import tts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [OP_W-1:0]  opcode,
  input  cell_t            inline_cell,
  input  logic [KEY_W-1:0] key_char,
  input  logic             cfg_wr,
  input  ds_wr_t           ds_wr,
  input  rs_wr_t           rs_wr,
  output sp_t              ds_raddr0,
  output sp_t              ds_raddr1,
  output sp_t              rs_raddr,
  output iss_t             iss
);

  sp_t  dp, rp;
  sp_t  dp_inc, dp_dec, rp_inc, rp_dec;
  sp_t  dp_next, rp_next;
  logic dp_inc_w, dp_dec_w, rp_inc_w, rp_dec_w;
  logic fault, halt_now, halted;

  always_comb begin
    dp_inc_w = (dp == SP_MAX);
    dp_dec_w = (dp == '0);
    rp_inc_w = (rp == SP_MAX);
    rp_dec_w = (rp == '0);
    dp_inc   = dp_inc_w ? '0 : dp + 1'b1;
    dp_dec   = dp_dec_w ? SP_MAX : dp - 1'b1;
    rp_inc   = rp_inc_w ? '0 : rp + 1'b1;
    rp_dec   = rp_dec_w ? SP_MAX : rp - 1'b1;
  end

  always_comb begin
    dp_next  = dp;
    rp_next  = rp;
    fault    = 1'b0;
    halt_now = 1'b0;
    unique case (opcode_t'(opcode)) inside
      OP_KEY, OP_LIT, OP_DUP: begin
        dp_next = dp_inc;
        fault   = dp_inc_w;
      end
      OP_EMIT, OP_DROP, OP_ADD, OP_JZ, OP_AND, OP_MAX, OP_GT, OP_PRINT: begin
        dp_next = dp_dec;
        fault   = dp_dec_w;
      end
      OP_ROT: begin
        // two pops then two pushes: pointer returns, wraps when it sits at 0 or 1
        fault = dp_dec_w || (dp_dec == '0);
      end
      OP_CALL: begin
        rp_next = rp_inc;
        fault   = rp_inc_w;
      end
      OP_EXIT: begin
        rp_next = rp_dec;
        fault   = rp_dec_w;
      end
      OP_DEC, OP_INC, OP_MUL2, OP_DIV2, OP_SWAP, OP_JUMP, OP_ZEQ: begin
      end
      default: begin
        halt_now = 1'b1;
      end
    endcase
  end

  assign ds_raddr0 = dp;
  assign ds_raddr1 = dp_dec;
  assign rs_raddr  = rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      dp     <= '0;
      rp     <= '0;
      halted <= 1'b0;
    end else if (cfg_wr) begin
      halted <= 1'b0;
    end else if (accept && !halted) begin
      dp     <= dp_next;
      rp     <= rp_next;
      halted <= halt_now;
    end
  end

  // Capture the item and any write landing on the entries being read.
  always_ff @(posedge clk) begin
    if (accept) begin
      iss.skip      <= halted;
      iss.op        <= opcode;
      iss.imm       <= inline_cell;
      iss.key       <= key_char;
      iss.fault     <= fault;
      iss.ra0       <= dp;
      iss.ra1       <= dp_dec;
      iss.wpush     <= dp_inc;
      iss.rwa       <= rp_inc;
      iss.fwd0      <= ds_wr.en && (ds_wr.addr == dp);
      iss.fwd1      <= ds_wr.en && (ds_wr.addr == dp_dec);
      iss.rfwd      <= rs_wr.en && (rs_wr.addr == rp);
      iss.fwd0_data <= ds_wr.data;
      iss.fwd1_data <= ds_wr.data;
      iss.rfwd_data <= rs_wr.data;
    end
  end

endmodule

FILE: design/tts_exec.sv
module tts_exec import tts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  iss_t              iss,
  input  cell_t             ds_rdata0,
  input  cell_t             ds_rdata1,
  input  addr_t             rs_rdata,
  input  logic              cfg_wr,
  input  logic [15:0]       cfg_start,
  input  logic              res_ready,
  output ex_stat_t          stat,
  output ds_wr_t            ds_wr,
  output rs_wr_t            rs_wr,
  output logic              res_valid,
  output logic [OUT_ADDR_W-1:0] res_next_address,
  output logic [KIND_W-1:0] res_out_kind,
  output cell_t             res_out_value,
  output logic              res_stack_fault
);

  logic   b_valid, b_adv;
  cell_t  t, t_next, a0, a1, value;
  addr_t  ia, ia_next, ia_plus1, ia_plus2, target, ra;
  kind_t  kind;
  logic   pend_valid;
  sp_t    pend_addr;
  cell_t  pend_data;
  opcode_t op;

  assign op       = opcode_t'(iss.op);
  assign b_adv    = b_valid && (!res_valid || res_ready);
  assign stat     = '{busy: b_valid, adv: b_adv, rot: (op == OP_ROT)};
  assign a0       = iss.fwd0 ? iss.fwd0_data : ds_rdata0;
  assign a1       = iss.fwd1 ? iss.fwd1_data : ds_rdata1;
  assign ra       = iss.rfwd ? iss.rfwd_data : rs_rdata;
  assign ia_plus1 = ia + addr_t'(1);
  assign ia_plus2 = ia + addr_t'(2);
  assign target   = iss.imm[ADDR_BITS-1:0];

  always_comb begin
    t_next  = t;
    ia_next = ia_plus1;
    kind    = KIND_NONE;
    value   = '0;
    unique case (op)
      OP_BYE:   begin kind = KIND_BYE; value = t; ia_next = ia; end
      OP_KEY:   t_next = {{(CELL_W-KEY_W){iss.key[KEY_W-1]}}, iss.key};
      OP_EMIT:  begin kind = KIND_EMIT; value = {{(CELL_W-8){1'b0}}, t[7:0]}; t_next = a0; end
      OP_CALL:  ia_next = target;
      OP_EXIT:  ia_next = ra;
      OP_LIT:   begin t_next = iss.imm; ia_next = ia_plus2; end
      OP_DUP:   ;
      OP_DROP:  t_next = a0;
      OP_DEC:   t_next = t - cell_t'(1);
      OP_INC:   t_next = t + cell_t'(1);
      OP_ADD:   t_next = t + a0;
      OP_MUL2:  t_next = t <<< 1;
      OP_DIV2:  t_next = t >>> 1;
      OP_SWAP:  t_next = a0;
      OP_JZ:    begin ia_next = (t == '0) ? target : ia_plus2; t_next = a0; end
      OP_JUMP:  ia_next = target;
      OP_ZEQ:   t_next = (t == '0) ? cell_t'(1) : '0;
      OP_ROT:   t_next = a1;
      OP_AND:   t_next = t & a0;
      OP_MAX:   t_next = (a0 > t) ? a0 : t;
      OP_GT:    t_next = (a0 > t) ? cell_t'(1) : '0;
      OP_PRINT: begin kind = KIND_PRINT; value = t; t_next = a0; end
      default:  begin kind = KIND_UNKNOWN; value = t; ia_next = ia; end
    endcase
    if (iss.skip) begin
      t_next  = t;
      ia_next = ia;
      kind    = KIND_NONE;
      value   = '0;
    end
  end

  // The second write of rot goes out in the cycle after rot leaves execute; no item is in execute then.
  always_comb begin
    ds_wr = '{en: 1'b0, addr: iss.ra0, data: t};
    if (pend_valid) begin
      ds_wr = '{en: 1'b1, addr: pend_addr, data: pend_data};
    end else if (b_adv && !iss.skip) begin
      case (op)
        OP_KEY, OP_LIT, OP_DUP: ds_wr = '{en: 1'b1, addr: iss.wpush, data: t};
        OP_SWAP, OP_ROT:        ds_wr = '{en: 1'b1, addr: iss.ra0, data: t};
        default:                ds_wr.en = 1'b0;
      endcase
    end
    rs_wr = '{en: b_adv && !iss.skip && (op == OP_CALL), addr: iss.rwa, data: ia_plus2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
      t          <= '0;
      ia         <= '0;
    end else begin
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      pend_valid <= b_adv && !iss.skip && (op == OP_ROT);
      if (cfg_wr) begin
        ia <= addr_t'(cfg_start);
      end else if (b_adv) begin
        ia <= ia_next;
        t  <= t_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && !iss.skip && (op == OP_ROT)) begin
      pend_addr <= iss.ra1;
      pend_data <= a0;
    end
    if (b_adv) begin
      res_next_address <= OUT_ADDR_W'(ia_next);
      res_out_kind     <= kind;
      res_out_value    <= value;
      res_stack_fault  <= iss.fault && !iss.skip;
    end
  end

endmodule

FILE: sim/token_threaded_stack_machine_tb.sv
module token_threaded_stack_machine_tb;
  import tts_pkg::*;

  typedef struct {
    logic [OP_W-1:0]   opcode;
    logic [CELL_W-1:0] inline_cell;
    logic [KEY_W-1:0]  key_char;
  } instr_t;

  typedef struct {
    logic [OUT_ADDR_W-1:0] next_address;
    kind_t                 out_kind;
    logic [CELL_W-1:0]     out_value;
    logic                  stack_fault;
  } outcome_t;

  logic clk;
  logic rst;

  tts_cfg_if cfg ();
  tts_cmd_if cmd ();
  tts_res_if res ();

  token_threaded_stack_machine u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .res (res)
  );

  // Shadow machine state, advanced when an instruction is queued. Items are
  // queued in program order and never dropped, so this stays in step with
  // what the core sees once each instruction is transferred.
  logic [CELL_W-1:0]    sh_tos;
  addr_t                sh_ia;
  logic [CELL_W-1:0]    sh_ds [STACK_DEPTH];
  bit                   sh_ds_ok [STACK_DEPTH];
  sp_t                  sh_dp;
  addr_t                sh_rs [STACK_DEPTH];
  bit                   sh_rs_ok [STACK_DEPTH];
  sp_t                  sh_rp;
  bit                   sh_halted;

  instr_t   instr_q [$];      // instructions waiting to be transferred
  outcome_t instr_out_q [$];  // their predicted outcomes, same order
  outcome_t outcome_q [$];    // outcomes of transferred instructions

  int tx_idle_pct;
  int rx_idle_pct;
  int fail_cnt;
  bit cmd_live;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.start_address = '0;
    cmd.valid = 1'b0;
    cmd.opcode = '0;
    cmd.inline_cell = '0;
    cmd.key_char = '0;
    res.ready = 1'b0;
    forever #10 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial begin
    #40000000;
    $display("token_threaded_stack_machine_tb NOT OK");
    $finish;
  end

  // Pointer moves; wrap past either end raises the fault for this step.
  function automatic sp_t sp_up(input sp_t p, inout bit flt);
    if (p == SP_MAX) flt = 1'b1;
    return p + 1'b1;
  endfunction

  function automatic sp_t sp_down(input sp_t p, inout bit flt);
    if (p == '0) flt = 1'b1;
    return p - 1'b1;
  endfunction

  // Pushes and pops on the shadow data stack.
  function automatic void ds_push(input logic [CELL_W-1:0] v, inout bit flt);
    sh_dp = sp_up(sh_dp, flt);
    sh_ds[sh_dp] = v;
    sh_ds_ok[sh_dp] = 1'b1;
  endfunction

  function automatic logic [CELL_W-1:0] ds_pop(inout bit flt);
    logic [CELL_W-1:0] v;
    v = sh_ds[sh_dp];
    sh_dp = sp_down(sh_dp, flt);
    return v;
  endfunction

  // True when the instruction touches only stack entries written before.
  function automatic bit reads_defined(input logic [OP_W-1:0] op);
    if (sh_halted) return 1'b1;
    case (op)
      OP_EMIT, OP_DROP, OP_ADD, OP_SWAP, OP_JZ, OP_AND, OP_MAX, OP_GT,
      OP_PRINT: return sh_ds_ok[sh_dp];
      OP_ROT:   return sh_ds_ok[sh_dp] && sh_ds_ok[sp_t'(sh_dp - 1'b1)];
      OP_EXIT:  return sh_rs_ok[sh_rp];
      default:  return 1'b1;
    endcase
  endfunction

  function automatic outcome_t execute(input instr_t it);
    outcome_t o;
    logic [CELL_W-1:0] t, a, b, key;
    addr_t nxt, tgt;
    bit flt;
    o.out_kind = KIND_NONE;
    o.out_value = '0;
    o.stack_fault = 1'b0;
    if (sh_halted) begin
      o.next_address = sh_ia;
      return o;
    end
    t = sh_tos;
    flt = 1'b0;
    tgt = it.inline_cell[ADDR_BITS-1:0];
    nxt = sh_ia + 1'b1;
    key = {{(CELL_W-KEY_W){it.key_char[KEY_W-1]}}, it.key_char};
    case (it.opcode)
      OP_BYE: begin
        o.out_kind = KIND_BYE; o.out_value = t; nxt = sh_ia; sh_halted = 1'b1;
      end
      OP_KEY: begin ds_push(t, flt); t = key; end
      OP_EMIT: begin
        o.out_kind = KIND_EMIT; o.out_value = {56'd0, t[7:0]}; t = ds_pop(flt);
      end
      OP_CALL: begin
        sh_rp = sp_up(sh_rp, flt);
        sh_rs[sh_rp] = sh_ia + 2'd2;
        sh_rs_ok[sh_rp] = 1'b1;
        nxt = tgt;
      end
      OP_EXIT: begin nxt = sh_rs[sh_rp]; sh_rp = sp_down(sh_rp, flt); end
      OP_LIT: begin ds_push(t, flt); t = it.inline_cell; nxt = sh_ia + 2'd2; end
      OP_DUP: ds_push(t, flt);
      OP_DROP: t = ds_pop(flt);
      OP_DEC: t = t - 1'b1;
      OP_INC: t = t + 1'b1;
      OP_ADD: t = t + ds_pop(flt);
      OP_MUL2: t = t << 1;
      OP_DIV2: t = {t[CELL_W-1], t[CELL_W-1:1]};
      OP_SWAP: begin a = sh_ds[sh_dp]; sh_ds[sh_dp] = t; t = a; end
      OP_JZ: begin
        nxt = (t == '0) ? tgt : addr_t'(sh_ia + 2'd2);
        t = ds_pop(flt);
      end
      OP_JUMP: nxt = tgt;
      OP_ZEQ: t = (t == '0) ? 64'd1 : 64'd0;
      OP_ROT: begin
        a = ds_pop(flt);
        b = ds_pop(flt);
        ds_push(a, flt);
        ds_push(t, flt);
        t = b;
      end
      OP_AND: t = t & ds_pop(flt);
      OP_MAX: begin a = ds_pop(flt); if ($signed(a) > $signed(t)) t = a; end
      OP_GT: begin a = ds_pop(flt); t = ($signed(a) > $signed(t)) ? 64'd1 : 64'd0; end
      OP_PRINT: begin o.out_kind = KIND_PRINT; o.out_value = t; t = ds_pop(flt); end
      default: begin
        o.out_kind = KIND_UNKNOWN; o.out_value = t; nxt = sh_ia; sh_halted = 1'b1;
      end
    endcase
    sh_tos = t;
    sh_ia = nxt;
    o.next_address = nxt;
    o.stack_fault = flt;
    return o;
  endfunction

  // Queue one instruction; one that would read a never-written entry
  // becomes a literal instead.
  task automatic queue_instr(input logic [OP_W-1:0] op, input logic [CELL_W-1:0] c,
                             input logic [KEY_W-1:0] k);
    instr_t it;
    it.opcode = reads_defined(op) ? op : OP_LIT;
    it.inline_cell = c;
    it.key_char = k;
    instr_out_q.push_back(execute(it));
    instr_q.push_back(it);
  endtask

  function automatic logic [CELL_W-1:0] pick_cell();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(40));
      2: case ($urandom_range(3))
           0: return 64'h7FFF_FFFF_FFFF_FFFF;
           1: return 64'h8000_0000_0000_0000;
           2: return '1;
           default: return '0;
         endcase
      default: return 64'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(199);
    if (r < 1) return OP_BYE;
    if (r < 2) return 8'($urandom_range(22, 255));
    if (r < 30) return OP_LIT;
    return 8'($urandom_range(OP_KEY, OP_PRINT));
  endfunction

  // Write the start address; the core must be idle.
  task automatic load_start(input logic [15:0] v);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.start_address <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sh_ia = v;
    sh_halted = 1'b0;
  endtask

  // Hold until every queued instruction has come back, then let the
  // pipeline settle.
  task automatic drain();
    while (instr_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Command driver: advance the queue on each transfer, then offer the next
  // instruction unless this cycle idles.
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      cmd_live = 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        outcome_q.push_back(instr_out_q.pop_front());
        void'(instr_q.pop_front());
        cmd_live = 1'b0;
      end
      if (!cmd_live) begin
        if (instr_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cmd.valid <= 1'b1;
          cmd.opcode <= instr_q[0].opcode;
          cmd.inline_cell <= instr_q[0].inline_cell;
          cmd.key_char <= instr_q[0].key_char;
          cmd_live = 1'b1;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest prediction.
  always @(posedge clk) begin : result_mon
    outcome_t e;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t unexpected result: addr %h kind %0d value %h fault %b", $time,
                   res.next_address, res.out_kind, res.out_value, res.stack_fault);
          fail_cnt++;
        end else begin
          e = outcome_q.pop_front();
          if (res.next_address !== e.next_address) begin
            $display("%0t next_address expected %h actual %h", $time,
                     e.next_address, res.next_address);
            fail_cnt++;
          end
          if (res.out_kind !== e.out_kind) begin
            $display("%0t out_kind expected %0d actual %0d", $time,
                     e.out_kind, res.out_kind);
            fail_cnt++;
          end
          if (res.out_value !== e.out_value) begin
            $display("%0t out_value expected %h actual %h", $time,
                     e.out_value, res.out_value);
            fail_cnt++;
          end
          if (res.stack_fault !== e.stack_fault) begin
            $display("%0t stack_fault expected %b actual %b", $time,
                     e.stack_fault, res.stack_fault);
            fail_cnt++;
          end
        end
      end
      res.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int n;
    fail_cnt = 0;
    tx_idle_pct = 14;
    rx_idle_pct = 73;
    sh_tos = '0;
    sh_ia = '0;
    sh_dp = '0;
    sh_rp = '0;
    sh_halted = 1'b0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      sh_ds[i] = '0;
      sh_ds_ok[i] = 1'b0;
      sh_rs[i] = '0;
      sh_rs_ok[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and every opcode except drop.
    load_start(16'h0000);
    queue_instr(OP_LIT, 64'h7FFF_FFFF_FFFF_FFFF, 9'h000);
    queue_instr(OP_LIT, 64'h8000_0000_0000_0000, 9'h0FF);
    queue_instr(OP_KEY, '0, 9'h0FF);
    queue_instr(OP_KEY, '1, 9'h1FF);
    queue_instr(OP_DUP, '0, 9'h100);
    queue_instr(OP_ADD, '0, 9'h000);
    queue_instr(OP_SWAP, '0, 9'h000);
    queue_instr(OP_ROT, '0, 9'h000);
    queue_instr(OP_MAX, '0, 9'h000);
    queue_instr(OP_LIT, 64'd5, 9'h000);
    queue_instr(OP_GT, '0, 9'h000);
    queue_instr(OP_AND, '0, 9'h000);
    queue_instr(OP_MUL2, '0, 9'h000);
    queue_instr(OP_DIV2, '0, 9'h000);
    queue_instr(OP_INC, '0, 9'h000);
    queue_instr(OP_DEC, '0, 9'h000);
    queue_instr(OP_ZEQ, '0, 9'h000);
    queue_instr(OP_EMIT, '0, 9'h000);
    queue_instr(OP_LIT, 64'h0, 9'h000);
    queue_instr(OP_JZ, 64'h1234_0000_0000_FFF0, 9'h000);
    queue_instr(OP_JUMP, 64'hFFFF_FFFF_FFFF_FFFE, 9'h000);
    queue_instr(OP_CALL, 64'h0000_0000_0000_0100, 9'h000);
    queue_instr(OP_EXIT, '0, 9'h000);
    queue_instr(OP_PRINT, '0, 9'h000);
    queue_instr(OP_BYE, '0, 9'h000);
    queue_instr(OP_DUP, '0, 9'h000);
    drain();

    // Unknown opcode halt, restart from the top of the address space so the
    // address wraps.
    load_start(16'hFFFF);
    queue_instr(OP_LIT, 64'd7, 9'h000);
    queue_instr(8'hFF, '0, 9'h000);
    queue_instr(OP_INC, '0, 9'h000);
    drain();

    // Random programs; idling swaps sides after three phases, then stops.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        tx_idle_pct = 73;
        rx_idle_pct = 14;
      end else if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph % 3)
        0: load_start(16'hFFFF);
        1: load_start(16'h0000);
        default: load_start(16'($urandom));
      endcase
      n = 86;
      for (int i = 0; i < n; i++) queue_instr(pick_op(), pick_cell(), 9'($urandom));
      drain();
    end

    if (fail_cnt == 0) begin
      $display("token_threaded_stack_machine_tb OK");
    end else begin
      $display("token_threaded_stack_machine_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: token_threaded_stack_machine.f
+incdir+design
design/tts_pkg.sv
design/tts_cmd_if.sv
design/tts_res_if.sv
design/tts_cfg_if.sv
design/tts_ram.sv
design/tts_issue.sv
design/tts_exec.sv
design/token_threaded_stack_machine.sv
sim/token_threaded_stack_machine_tb.sv
